>>> design/tpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types and sizes for the TLB / page table translation block.
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int PAGE_BYTES  = 256;

    localparam int VA_W     = 16;
    localparam int FRAME_W  = 8;
    localparam int OFFSET_W = $clog2(PAGE_BYTES);
    localparam int PAGE_W   = $clog2(PAGE_COUNT);
    localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
    // frame counter saturates one past the largest 8-bit frame
    localparam int FREE_W   = FRAME_W + 1;
    localparam logic [FREE_W-1:0] FREE_LIMIT = FREE_W'(1 << FRAME_W);

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } t_state;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } t_tlb_lookup;

    typedef struct packed {
        logic               en;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_tlb_fill;

endpackage

>>> design/tpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module tpt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/tpt_tlb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_tlb
// Fully associative TLB with parallel tag compare and FIFO slot replacement.
// ----------------------------------------------------------------------------
module tpt_tlb (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tpt_pkg::PAGE_W-1:0]  i_page,
    input  tpt_pkg::t_tlb_fill          i_fill,
    output tpt_pkg::t_tlb_lookup        o_lookup
);

    logic [tpt_pkg::PAGE_W-1:0]    r_tag   [tpt_pkg::TLB_ENTRIES];
    logic [tpt_pkg::FRAME_W-1:0]   r_frame [tpt_pkg::TLB_ENTRIES];
    logic [tpt_pkg::TLB_ENTRIES-1:0] r_valid;
    logic [tpt_pkg::TLB_IDX_W-1:0] r_slot;
    logic [tpt_pkg::TLB_IDX_W-1:0] n_slot;

    // lowest matching index wins: scan from the top down
    always_comb begin
        o_lookup.hit   = 1'b0;
        o_lookup.frame = '0;
        for (int i = tpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == i_page)) begin
                o_lookup.hit   = 1'b1;
                o_lookup.frame = r_frame[i];
            end
        end
    end

    always_comb begin
        if (r_slot == tpt_pkg::TLB_IDX_W'(tpt_pkg::TLB_ENTRIES - 1)) begin
            n_slot = '0;
        end else begin
            n_slot = r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_slot  <= '0;
        end else if (i_fill.en) begin
            r_valid[r_slot] <= 1'b1;
            r_slot          <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fill.en) begin
            r_tag[r_slot]   <= i_fill.page;
            r_frame[r_slot] <= i_fill.frame;
        end
    end

endmodule

>>> design/tlb_page_table_translate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translate
// Virtual-to-physical translation through a TLB backed by a page table.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with i_virtual_address. A transfer
// happens on a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with physical address, frame,
// TLB-hit and page-fault flags; one result per address, in order.
// Timing: an address is taken in the idle state, the page-table RAM is read
// at that edge, and the resolve state then compares the TLB, resolves the
// frame, writes back the page table / TLB and loads the output register.
// No new address is taken until the resolve step is done; this is set by
// the registered read of the page-table RAM.
// The output register lets a new address be taken while a result waits;
// if the receiver stalls and the output register is still full, the
// resolve step holds until it drains.
// Reset (synchronous, active low) clears TLB valid bits, the fill slot,
// the page-mapped bits and the free-frame counter; no clearing pass is
// needed, the page-table RAM read data is used only for mapped pages.
// ----------------------------------------------------------------------------
module tlb_page_table_translate (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tpt_pkg::VA_W-1:0]     i_virtual_address,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tpt_pkg::VA_W-1:0]     o_physical_address,
    output logic [tpt_pkg::FRAME_W-1:0]  o_frame_number,
    output logic                         o_tlb_hit,
    output logic                         o_page_fault
);

    tpt_pkg::t_state r_state;
    tpt_pkg::t_state n_state;

    logic [tpt_pkg::PAGE_W-1:0]   r_page;
    logic [tpt_pkg::OFFSET_W-1:0] r_offset;
    logic [tpt_pkg::PAGE_COUNT-1:0] r_page_mapped;
    logic [tpt_pkg::FREE_W-1:0]   r_next_free;

    logic                         r_out_valid;
    logic [tpt_pkg::VA_W-1:0]     r_out_pa;
    logic [tpt_pkg::FRAME_W-1:0]  r_out_frame;
    logic                         r_out_hit;
    logic                         r_out_fault;

    logic                         in_xfer;
    logic                         resolve_go;
    logic [tpt_pkg::PAGE_W-1:0]   in_page;
    logic [tpt_pkg::FRAME_W-1:0]  pt_rd_data;
    logic                         mapped;
    logic                         fault;
    logic [tpt_pkg::FRAME_W-1:0]  frame;
    logic [tpt_pkg::FRAME_W-1:0]  new_frame;
    logic [23:0]                  pa_full;

    tpt_pkg::t_tlb_lookup tlb_lookup;
    tpt_pkg::t_tlb_fill   tlb_fill;

    assign in_page = i_virtual_address[tpt_pkg::OFFSET_W +: tpt_pkg::PAGE_W];
    assign in_xfer = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tpt_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = tpt_pkg::ST_RESOLVE;
                end
            end
            tpt_pkg::ST_RESOLVE: begin
                if (resolve_go) begin
                    n_state = tpt_pkg::ST_IDLE;
                end
            end
            default: n_state = tpt_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        resolve_go = 1'b0;
        case (r_state)
            tpt_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            tpt_pkg::ST_RESOLVE: begin
                resolve_go = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    tpt_ram #(
        .DATA_W (tpt_pkg::FRAME_W),
        .DEPTH  (tpt_pkg::PAGE_COUNT)
    ) u_page_table (
        .i_clk     (i_clk),
        .i_wr_en   (resolve_go && fault),
        .i_wr_addr (r_page),
        .i_wr_data (new_frame),
        .i_rd_en   (in_xfer),
        .i_rd_addr (in_page),
        .o_rd_data (pt_rd_data)
    );

    tpt_tlb u_tlb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_page   (r_page),
        .i_fill   (tlb_fill),
        .o_lookup (tlb_lookup)
    );

    // writes land at the resolve edge, before the next read can be issued
    assign mapped    = r_page_mapped[r_page];
    assign fault     = !tlb_lookup.hit && !mapped;
    assign new_frame = r_next_free[tpt_pkg::FRAME_W-1:0];

    always_comb begin
        if (tlb_lookup.hit) begin
            frame = tlb_lookup.frame;
        end else if (mapped) begin
            frame = pt_rd_data;
        end else begin
            frame = new_frame;
        end
    end

    assign pa_full = (24'(frame) << tpt_pkg::OFFSET_W) | 24'(r_offset);

    assign tlb_fill.en    = resolve_go && !tlb_lookup.hit;
    assign tlb_fill.page  = r_page;
    assign tlb_fill.frame = frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tpt_pkg::ST_IDLE;
            r_page_mapped <= '0;
            r_next_free   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (resolve_go && fault) begin
                r_page_mapped[r_page] <= 1'b1;
                if (r_next_free < tpt_pkg::FREE_LIMIT) begin
                    r_next_free <= r_next_free + 1'b1;
                end
            end
            if (resolve_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_page   <= in_page;
            r_offset <= i_virtual_address[tpt_pkg::OFFSET_W-1:0];
        end
        if (resolve_go) begin
            r_out_pa    <= pa_full[tpt_pkg::VA_W-1:0];
            r_out_frame <= frame;
            r_out_hit   <= tlb_lookup.hit;
            r_out_fault <= fault;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_physical_address = r_out_pa;
    assign o_frame_number     = r_out_frame;
    assign o_tlb_hit          = r_out_hit;
    assign o_page_fault       = r_out_fault;

`ifndef ASSERT_OFF
    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_tlb_hit && o_page_fault))
        else $error("hit and fault flagged together");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("second address taken during resolve");

    a_resolve_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        resolve_go |=> (o_out_valid && (r_state == tpt_pkg::ST_IDLE)))
        else $error("resolved result not presented");

    a_fault_maps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (resolve_go && fault) |=> r_page_mapped[$past(r_page)])
        else $error("faulting page left unmapped");
`endif

endmodule
